// ----- rtl/core/pma_pkg.sv -----
`default_nettype none

package pma_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 3;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_CRIT          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_THREE_QUARTER = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL      = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY         = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_QUARTER       = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF          = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE_QUARTER = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL          = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] crit_mv;
        logic [SAMPLE_W-1:0] empty_mv;
        logic [SAMPLE_W-1:0] quarter_mv;
        logic [SAMPLE_W-1:0] half_mv;
        logic [SAMPLE_W-1:0] three_quarter_mv;
    } t_levels;

    localparam t_levels LEVELS_RESET = '{
        crit_mv:          16'd3400,
        empty_mv:         16'd3500,
        quarter_mv:       16'd3650,
        half_mv:          16'd3800,
        three_quarter_mv: 16'd3950
    };

endpackage

`default_nettype wire

// ----- rtl/core/pma_window.sv -----
`default_nettype none

module pma_window #(
    parameter int DEPTH = 8
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_load,
    input  wire logic                                           i_prime,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]                   i_sample,
    output logic      [pma_pkg::SAMPLE_W+$clog2(DEPTH)-1:0]     o_sum
);
    import pma_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);

    // The window is a shift line: the newest sample enters tap zero and the
    // oldest leaves from the last tap, so the running sum needs only one tap.
    logic [SAMPLE_W-1:0] r_taps [DEPTH];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    always_comb begin
        if (i_prime) begin
            n_sum = SUM_W'(i_sample) * SUM_W'(DEPTH);
        end else begin
            n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(r_taps[DEPTH-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_taps[k] <= '0;
            end
        end else if (i_load) begin
            r_sum <= n_sum;
            if (i_prime) begin
                for (int k = 0; k < DEPTH; k++) begin
                    r_taps[k] <= i_sample;
                end
            end else begin
                r_taps[0] <= i_sample;
                for (int k = 1; k < DEPTH; k++) begin
                    r_taps[k] <= r_taps[k-1];
                end
            end
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ----- rtl/core/pma_mean.sv -----
`default_nettype none

module pma_mean #(
    parameter int DEPTH = 8
) (
    input  wire logic [pma_pkg::SAMPLE_W+$clog2(DEPTH)-1:0] i_sum,
    output logic      [pma_pkg::SAMPLE_W-1:0]               o_mean
);
    import pma_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
    localparam int SHIFT  = SUM_W + $clog2(DEPTH);
    localparam int MULT_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] RECIP =
        MULT_W'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    // Division by the depth as a multiplication by a rounded-up reciprocal;
    // the extra fraction bits make the truncated quotient exact for any sum.
    logic [PROD_W-1:0] product;

    assign product = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign o_mean  = product[SHIFT +: SAMPLE_W];

endmodule

`default_nettype wire

// ----- rtl/core/pma_level.sv -----
`default_nettype none

module pma_level (
    input  wire logic [pma_pkg::SAMPLE_W-1:0] i_mean_mv,
    input  wire pma_pkg::t_levels             i_levels,
    output logic      [pma_pkg::LEVEL_W-1:0]  o_level
);
    import pma_pkg::*;

    always_comb begin
        priority if (i_mean_mv <= i_levels.crit_mv) begin
            o_level = LEVEL_CRITICAL;
        end else if (i_mean_mv <= i_levels.empty_mv) begin
            o_level = LEVEL_EMPTY;
        end else if (i_mean_mv <= i_levels.quarter_mv) begin
            o_level = LEVEL_QUARTER;
        end else if (i_mean_mv <= i_levels.half_mv) begin
            o_level = LEVEL_HALF;
        end else if (i_mean_mv <= i_levels.three_quarter_mv) begin
            o_level = LEVEL_THREE_QUARTER;
        end else begin
            o_level = LEVEL_FULL;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/power_monitor_moving_average.sv -----
// Throughput: one item per cycle unless stalled; each accepted item updates every window,
// except that the battery window is updated only when i_battery_valid is set.
// Stages: window and running-sum update, reciprocal multiply for the means, level and output.
// Reset is synchronous and active low: windows and sums clear to zero, thresholds
// return to their defaults and all stage valid flags clear.
`default_nettype none

module power_monitor_moving_average #(
    parameter int BATTERY_DEPTH = 8,
    parameter int AUX_DEPTH     = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_cfg_wr_en,
    input  wire logic [pma_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]        i_cfg_data,

    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]        i_battery_mv,
    input  wire logic                                i_battery_valid,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]        i_load_ma,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]        i_usb_mv,
    input  wire logic [pma_pkg::SAMPLE_W-1:0]        i_usb_ma,
    input  wire logic                                i_prime,

    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic      [pma_pkg::SAMPLE_W-1:0]        o_battery_avg_mv,
    output logic      [pma_pkg::SAMPLE_W-1:0]        o_load_avg_ma,
    output logic      [pma_pkg::SAMPLE_W-1:0]        o_usb_avg_mv,
    output logic      [pma_pkg::SAMPLE_W-1:0]        o_usb_avg_ma,
    output logic      [pma_pkg::LEVEL_W-1:0]         o_battery_level
);
    import pma_pkg::*;

    localparam int BAT_SUM_W = SAMPLE_W + $clog2(BATTERY_DEPTH);
    localparam int AUX_SUM_W = SAMPLE_W + $clog2(AUX_DEPTH);

    t_levels r_levels;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic accept;

    logic [BAT_SUM_W-1:0] bat_sum;
    logic [AUX_SUM_W-1:0] load_sum;
    logic [AUX_SUM_W-1:0] usb_v_sum;
    logic [AUX_SUM_W-1:0] usb_a_sum;

    logic [SAMPLE_W-1:0] bat_mean;
    logic [SAMPLE_W-1:0] load_mean;
    logic [SAMPLE_W-1:0] usb_v_mean;
    logic [SAMPLE_W-1:0] usb_a_mean;

    logic [SAMPLE_W-1:0] r_mean_bat;
    logic [SAMPLE_W-1:0] r_mean_load;
    logic [SAMPLE_W-1:0] r_mean_usb_v;
    logic [SAMPLE_W-1:0] r_mean_usb_a;

    logic [LEVEL_W-1:0] level;

    logic [SAMPLE_W-1:0] r_out_bat;
    logic [SAMPLE_W-1:0] r_out_load;
    logic [SAMPLE_W-1:0] r_out_usb_v;
    logic [SAMPLE_W-1:0] r_out_usb_a;
    logic [LEVEL_W-1:0]  r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CRIT:          r_levels.crit_mv          <= i_cfg_data;
                REG_EMPTY:         r_levels.empty_mv         <= i_cfg_data;
                REG_QUARTER:       r_levels.quarter_mv       <= i_cfg_data;
                REG_HALF:          r_levels.half_mv          <= i_cfg_data;
                REG_THREE_QUARTER: r_levels.three_quarter_mv <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept  = i_valid && en1;

    // An invalid battery sample leaves the battery window untouched, prime or not.
    pma_window #(.DEPTH(BATTERY_DEPTH)) u_bat_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && i_battery_valid),
        .i_prime  (i_prime),
        .i_sample (i_battery_mv),
        .o_sum    (bat_sum)
    );

    pma_window #(.DEPTH(AUX_DEPTH)) u_load_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_prime  (i_prime),
        .i_sample (i_load_ma),
        .o_sum    (load_sum)
    );

    pma_window #(.DEPTH(AUX_DEPTH)) u_usb_v_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_prime  (i_prime),
        .i_sample (i_usb_mv),
        .o_sum    (usb_v_sum)
    );

    pma_window #(.DEPTH(AUX_DEPTH)) u_usb_a_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_prime  (i_prime),
        .i_sample (i_usb_ma),
        .o_sum    (usb_a_sum)
    );

    pma_mean #(.DEPTH(BATTERY_DEPTH)) u_bat_mean (
        .i_sum  (bat_sum),
        .o_mean (bat_mean)
    );

    pma_mean #(.DEPTH(AUX_DEPTH)) u_load_mean (
        .i_sum  (load_sum),
        .o_mean (load_mean)
    );

    pma_mean #(.DEPTH(AUX_DEPTH)) u_usb_v_mean (
        .i_sum  (usb_v_sum),
        .o_mean (usb_v_mean)
    );

    pma_mean #(.DEPTH(AUX_DEPTH)) u_usb_a_mean (
        .i_sum  (usb_a_sum),
        .o_mean (usb_a_mean)
    );

    pma_level u_level (
        .i_mean_mv (r_mean_bat),
        .i_levels  (r_levels),
        .o_level   (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_mean_bat   <= bat_mean;
            r_mean_load  <= load_mean;
            r_mean_usb_v <= usb_v_mean;
            r_mean_usb_a <= usb_a_mean;
        end
        if (en3) begin
            r_out_bat   <= r_mean_bat;
            r_out_load  <= r_mean_load;
            r_out_usb_v <= r_mean_usb_v;
            r_out_usb_a <= r_mean_usb_a;
            r_out_level <= level;
        end
    end

    assign o_valid          = r_v3;
    assign o_battery_avg_mv = r_out_bat;
    assign o_load_avg_ma    = r_out_load;
    assign o_usb_avg_mv     = r_out_usb_v;
    assign o_usb_avg_ma     = r_out_usb_a;
    assign o_battery_level  = r_out_level;

    a_rise_from_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v2))
        else $error("result appeared without an item in the mean stage");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en2) |=> (r_v2 && $stable(r_mean_bat) && $stable(r_mean_load)))
        else $error("held mean stage was overwritten");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_battery_level <= LEVEL_FULL))
        else $error("battery level out of range");

endmodule

`default_nettype wire
